[hdl/qcis_pkg.sv]
// Package for the quadratic colouring independent set search block.
// Holds the transfer payload types and the fixed field widths.
// No dependencies.
package qcis_pkg;

  localparam int unsigned COEF_W   = 3;
  localparam int unsigned COLOUR_W = 3;
  localparam int unsigned MEMBER_W = 5;

  typedef struct packed {
    logic [COEF_W-1:0] coef_a;
    logic [COEF_W-1:0] coef_b;
    logic [COEF_W-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic                colouring_ok;
    logic [COLOUR_W-1:0] found_colour;
    logic [MEMBER_W-1:0] member_0;
    logic [MEMBER_W-1:0] member_1;
    logic [MEMBER_W-1:0] member_2;
    logic [MEMBER_W-1:0] member_3;
    logic [MEMBER_W-1:0] member_4;
    logic [MEMBER_W-1:0] member_5;
  } result_t;

endpackage

[hdl/qcis_colour.sv]
// Edge colour unit: decides whether the edge between vertices u and w has the
// target colour. Small constant tables do the modular products and the final reduction.
// Depends on qcis_pkg.
module qcis_colour #(
  parameter int unsigned MODULUS      = 5,
  parameter int unsigned VERTEX_COUNT = 26,
  parameter int unsigned VW           = 5
) (
  input  qcis_pkg::coef_t                  coef_i,
  input  logic [VW-1:0]                    u_i,
  input  logic [VW-1:0]                    w_i,
  input  logic [qcis_pkg::COLOUR_W-1:0]    target_i,
  output logic                             hit_o
);

  localparam int unsigned CW     = qcis_pkg::COLOUR_W;
  localparam int unsigned MM_N   = 1 << (2 * qcis_pkg::COEF_W);
  localparam int unsigned HALF   = (MODULUS % 2 == 1) ? (MODULUS + 1) / 2 : MODULUS - 1;
  localparam int unsigned INF    = VERTEX_COUNT - 1;

  logic [CW-1:0] xr_tab [VERTEX_COUNT];
  logic [CW-1:0] y_tab  [VERTEX_COUNT];
  logic [VW-1:0] x_tab  [VERTEX_COUNT];
  logic [CW-1:0] mm_tab [MM_N];
  logic [CW-1:0] am_tab [32];

  for (genvar i = 0; i < VERTEX_COUNT; i++) begin : g_vtx
    assign xr_tab[i] = CW'((i / MODULUS) % MODULUS);
    assign y_tab[i]  = CW'(i % MODULUS);
    assign x_tab[i]  = VW'(i / MODULUS);
  end

  for (genvar i = 0; i < MM_N; i++) begin : g_mm
    assign mm_tab[i] = CW'(((i / 8) * (i % 8)) % MODULUS);
  end

  for (genvar i = 0; i < 32; i++) begin : g_am
    assign am_tab[i] = CW'(i % MODULUS);
  end

  logic [CW-1:0] a_r, b_r, c_r;
  logic [CW-1:0] xru, xrw, yu, yw, dx, dy, xs, mid;
  logic [CW:0]   xsum;
  logic [CW-1:0] dxx, dxy, dyy, ta, tb, tc;
  logic [4:0]    tot;

  always_comb begin
    a_r  = mm_tab[{coef_i.coef_a, 3'd1}];
    b_r  = mm_tab[{coef_i.coef_b, 3'd1}];
    c_r  = mm_tab[{coef_i.coef_c, 3'd1}];
    xru  = xr_tab[u_i];
    xrw  = xr_tab[w_i];
    yu   = y_tab[u_i];
    yw   = y_tab[w_i];
    dx   = (xrw >= xru) ? xrw - xru : xrw + CW'(MODULUS) - xru;
    dy   = (yw >= yu) ? yw - yu : yw + CW'(MODULUS) - yu;
    xsum = {1'b0, xru} + {1'b0, xrw};
    xs   = (xsum >= (CW + 1)'(MODULUS)) ? CW'(xsum - (CW + 1)'(MODULUS)) : CW'(xsum);
    mid  = mm_tab[{CW'(HALF), xs}];
    dxx  = mm_tab[{dx, dx}];
    dxy  = mm_tab[{dx, dy}];
    dyy  = mm_tab[{dy, dy}];
    ta   = mm_tab[{a_r, dxx}];
    tb   = mm_tab[{b_r, dxy}];
    tc   = mm_tab[{c_r, dyy}];
    tot  = 5'(mid) + 5'(ta) + 5'(tb) + 5'(tc);
    if (w_i == VW'(INF)) begin
      hit_o = (x_tab[u_i] == VW'(target_i));
    end else begin
      hit_o = (am_tab[tot] == target_i);
    end
  end

endmodule

[hdl/quadratic_colouring_indep_set_search.sv]
// Top level of the quadratic colouring independent set search block.
// Sequencer, candidate and chosen stacks, and the output register.
// Depends on qcis_pkg and qcis_colour.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | in_data_i  (qcis_pkg::coef_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (qcis_pkg::result_t)
//
// The run time of one item is data dependent and set by the one edge colour unit: per
// colour a start state and any failed count checks, and per vertex pick a check plus a
// sweep over the higher vertices (none after the last pick), a check for a full set, and
// the steps that load the item and hand the result over.
// Reset clears the sequencer and all registers; no clearing pass is needed.
// The block is ready only when idle, and a finished search waits while the output register
// still holds a result that has not been taken.
module quadratic_colouring_indep_set_search #(
  parameter int unsigned MODULUS      = 5,
  parameter int unsigned VERTEX_COUNT = 26,
  parameter int unsigned SET_SIZE     = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qcis_pkg::coef_t     in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qcis_pkg::result_t   out_data_o
);

  localparam int unsigned VW  = $clog2(VERTEX_COUNT);
  localparam int unsigned CNW = $clog2(VERTEX_COUNT + 1);
  localparam int unsigned LVW = $clog2(SET_SIZE + 1);
  localparam int unsigned LIW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
  localparam int unsigned CW  = qcis_pkg::COLOUR_W;
  localparam int unsigned MW  = qcis_pkg::MEMBER_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_CHECK,
    S_SWEEP,
    S_FINISH
  } state_e;

  state_e                  state_q;
  qcis_pkg::coef_t         coef_q;
  logic [CW-1:0]           colour_q;
  logic [LVW-1:0]          level_q;
  logic [VERTEX_COUNT-1:0] cand_q [SET_SIZE];
  logic [CNW-1:0]          cnt_q  [SET_SIZE];
  logic [VW-1:0]           chosen_q [SET_SIZE];
  logic [VERTEX_COUNT-1:0] work_q;
  logic [CNW-1:0]          work_cnt_q;
  logic [VW-1:0]           vtx_q;
  logic [VW-1:0]           w_q;
  logic                    res_ok_q;
  logic                    out_valid_q;
  qcis_pkg::result_t       out_data_q;

  logic [LIW-1:0]          lvl;
  logic [LIW-1:0]          nlvl;
  logic [VERTEX_COUNT-1:0] cur_cand;
  logic [CNW-1:0]          cur_cnt;
  logic [CNW-1:0]          need;
  logic [VW-1:0]           lo_idx;
  logic [VERTEX_COUNT-1:0] picked;
  logic                    hit;
  logic                    clr;
  logic [VERTEX_COUNT-1:0] work_d;
  logic [CNW-1:0]          work_cnt_d;
  logic [MW-1:0]           member [6];

  assign lvl      = level_q[LIW-1:0];
  assign nlvl     = lvl + LIW'(1);
  assign cur_cand = cand_q[lvl];
  assign cur_cnt  = cnt_q[lvl];
  assign need     = CNW'(SET_SIZE) - CNW'(level_q);

  always_comb begin
    lo_idx = '0;
    for (int i = VERTEX_COUNT - 1; i >= 0; i--) begin
      if (cur_cand[i]) begin
        lo_idx = VW'(i);
      end
    end
  end

  assign picked = cur_cand & ~({{(VERTEX_COUNT - 1){1'b0}}, 1'b1} << lo_idx);

  qcis_colour #(
    .MODULUS      (MODULUS),
    .VERTEX_COUNT (VERTEX_COUNT),
    .VW           (VW)
  ) u_colour (
    .coef_i   (coef_q),
    .u_i      (vtx_q),
    .w_i      (w_q),
    .target_i (colour_q),
    .hit_o    (hit)
  );

  assign clr        = hit && work_q[w_q];
  assign work_d     = clr ? (work_q & ~({{(VERTEX_COUNT - 1){1'b0}}, 1'b1} << w_q)) : work_q;
  assign work_cnt_d = clr ? work_cnt_q - CNW'(1) : work_cnt_q;

  for (genvar k = 0; k < 6; k++) begin : g_member
    if (k < SET_SIZE) begin : g_used
      assign member[k] = res_ok_q ? '0 : MW'(chosen_q[k]);
    end else begin : g_unused
      assign member[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      coef_q      <= '0;
      colour_q    <= '0;
      level_q     <= '0;
      cand_q      <= '{default: '0};
      cnt_q       <= '{default: '0};
      chosen_q    <= '{default: '0};
      work_q      <= '0;
      work_cnt_q  <= '0;
      vtx_q       <= '0;
      w_q         <= '0;
      res_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            coef_q   <= in_data_i;
            colour_q <= '0;
            state_q  <= S_INIT;
          end
        end
        S_INIT: begin
          level_q  <= '0;
          cand_q[0] <= '1;
          cnt_q[0]  <= CNW'(VERTEX_COUNT);
          state_q  <= S_CHECK;
        end
        S_CHECK: begin
          if (level_q == LVW'(SET_SIZE)) begin
            res_ok_q <= 1'b0;
            state_q  <= S_FINISH;
          end else if (cur_cnt < need) begin
            if (level_q == '0) begin
              if (colour_q == CW'(MODULUS - 1)) begin
                res_ok_q <= 1'b1;
                state_q  <= S_FINISH;
              end else begin
                colour_q <= colour_q + CW'(1);
                state_q  <= S_INIT;
              end
            end else begin
              level_q <= level_q - LVW'(1);
            end
          end else begin
            cand_q[lvl]   <= picked;
            cnt_q[lvl]    <= cur_cnt - CNW'(1);
            chosen_q[lvl] <= lo_idx;
            work_q        <= picked;
            work_cnt_q    <= cur_cnt - CNW'(1);
            vtx_q         <= lo_idx;
            w_q           <= lo_idx + VW'(1);
            if (level_q == LVW'(SET_SIZE - 1)) begin
              level_q <= level_q + LVW'(1);
            end else if (lo_idx == VW'(VERTEX_COUNT - 1)) begin
              cand_q[nlvl] <= picked;
              cnt_q[nlvl]  <= cur_cnt - CNW'(1);
              level_q      <= level_q + LVW'(1);
            end else begin
              state_q <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          work_q     <= work_d;
          work_cnt_q <= work_cnt_d;
          w_q        <= w_q + VW'(1);
          if (w_q == VW'(VERTEX_COUNT - 1)) begin
            cand_q[nlvl] <= work_d;
            cnt_q[nlvl]  <= work_cnt_d;
            level_q      <= level_q + LVW'(1);
            state_q      <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q               <= 1'b1;
            out_data_q.colouring_ok   <= res_ok_q;
            out_data_q.found_colour   <= res_ok_q ? '0 : colour_q;
            out_data_q.member_0       <= member[0];
            out_data_q.member_1       <= member[1];
            out_data_q.member_2       <= member[2];
            out_data_q.member_3       <= member[3];
            out_data_q.member_4       <= member[4];
            out_data_q.member_5       <= member[5];
            state_q                   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVW'(SET_SIZE))
    else $error("search level beyond set size");

  a_sweep_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP |-> work_cnt_q == CNW'($countones(work_q)))
    else $error("sweep candidate count does not match its mask");

  a_check_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && level_q < LVW'(SET_SIZE))
      |-> cur_cnt == CNW'($countones(cur_cand)))
    else $error("stack candidate count does not match its mask");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready after an accepted transfer");

  a_colour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.found_colour < CW'(MODULUS))
    else $error("reported colour out of range");

endmodule
